// File: rtl/hnx_pkg.sv
`default_nettype none

package hnx_pkg;

    localparam int unsigned TAG_LEN = 13;
    localparam int unsigned TAG_W   = 4;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_TAG0  = 8'h48;

    // One result item as it waits in the output register.
    typedef struct packed {
        logic [7:0] name_char;
        logic [4:0] name_length;
        logic       char_valid;
        logic       done_res;
        logic       found;
    } result_t;

    // Characters of the tag "H Craft name:".
    function automatic logic [7:0] tag_char(input logic [TAG_W-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h20;
            4'd2:    c = 8'h43;
            4'd3:    c = 8'h72;
            4'd4:    c = 8'h61;
            4'd5:    c = 8'h66;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h20;
            4'd8:    c = 8'h6E;
            4'd9:    c = 8'h61;
            4'd10:   c = 8'h6D;
            4'd11:   c = 8'h65;
            4'd12:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] clean_byte(input logic [7:0] c);
        logic ok;
        ok = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DASH ||
             c == CH_DOT;
        return ok ? c : CH_UNDER;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hnx_out_stage.sv
`default_nettype none

module hnx_out_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire hnx_pkg::result_t load_data,
    output logic                 can_accept,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output hnx_pkg::result_t     out_data
);
    import hnx_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // A new item may enter while the held one is being taken.
    assign can_accept = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_accept)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_accept && load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/header_tag_name_extractor.sv
`default_nettype none

// Channel   Dir  tdata                                 tuser                      tlast
// s_axis    in   [7:0] data_byte                       -                          last_in_chunk
// m_axis    out  [7:0] name_char, [12:8] name_length   [0] char_valid, [1] found  done_res
//
// A new item can be accepted every cycle while s_tready is high.
// Results appear in the cycle after the causing item is accepted, from one output register.
// Input is stalled only while a result is held and m_tready is low.
// rst_n clears the search state and the output valid flag at once; no clearing pass.

module header_tag_name_extractor #(
    parameter int unsigned NAME_MAX = 31
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_in_chunk
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] name_char, [12:8] name_length, zero pad
    output logic [1:0]       m_tuser,   // [0] char_valid, [1] found
    output logic             m_tlast    // done_res
);
    import hnx_pkg::*;

    localparam int unsigned CW = $clog2(NAME_MAX + 1);
    localparam int unsigned LW = CW + 5;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_CAPTURE,
        PH_FINISHED
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    logic             accept;
    logic             emit;
    result_t          res;
    result_t          out_res;
    logic             stage_ready;
    logic [TAG_W-1:0] tag_adv;
    logic [CW-1:0]    cnt_inc;
    logic [LW-1:0]    cnt_ext;
    logic [LW-1:0]    inc_ext;
    logic             is_eol;
    logic             cap_done;

    assign s_tready = stage_ready;
    assign accept   = s_tvalid && stage_ready;
    assign is_eol   = (s_tdata == CH_LF) || (s_tdata == CH_CR);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign cnt_ext  = LW'(cnt_reg);
    assign inc_ext  = LW'(cnt_inc);
    assign cap_done = (cnt_inc >= CW'(NAME_MAX)) || s_tlast;

    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        res        = '0;
        tag_adv    = '0;

        unique case (phase_reg)
            PH_SEARCH:
            begin
                // On any mismatch, restart from the first tag character (an 'H' counts as its match).
                if (s_tdata == tag_char(tag_reg))
                begin
                    tag_adv = tag_reg + 1'b1;
                end
                else
                begin
                    tag_adv = (s_tdata == CH_TAG0) ? TAG_W'(1) : '0;
                end
                tag_next = tag_adv;
                if (tag_adv == TAG_W'(TAG_LEN))
                begin
                    tag_next = '0;
                    if (!s_tlast)
                    begin
                        phase_next = PH_CAPTURE;
                        cnt_next   = '0;
                    end
                end
                if (s_tlast)
                begin
                    emit         = 1'b1;
                    res.done_res = 1'b1;
                end
            end
            PH_CAPTURE:
            begin
                if (is_eol)
                begin
                    if (cnt_reg == '0)
                    begin
                        // Empty name: go back to searching.
                        phase_next = PH_SEARCH;
                        tag_next   = '0;
                        if (s_tlast)
                        begin
                            emit         = 1'b1;
                            res.done_res = 1'b1;
                        end
                    end
                    else
                    begin
                        emit            = 1'b1;
                        res.done_res    = 1'b1;
                        res.found       = 1'b1;
                        res.name_length = cnt_ext[4:0];
                        phase_next      = PH_FINISHED;
                    end
                end
                else
                begin
                    cnt_next        = cnt_inc;
                    emit            = 1'b1;
                    res.name_char   = clean_byte(s_tdata);
                    res.char_valid  = 1'b1;
                    res.done_res    = cap_done;
                    res.found       = cap_done;
                    res.name_length = inc_ext[4:0];
                    if (cap_done)
                    begin
                        phase_next = PH_FINISHED;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (s_tlast)
        begin
            phase_next = PH_SEARCH;
            tag_next   = '0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            tag_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            cnt_reg   <= cnt_next;
        end
    end

    hnx_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && emit),
        .load_data  (res),
        .can_accept (stage_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {3'b000, out_res.name_length, out_res.name_char};
    assign m_tuser = {out_res.found, out_res.char_valid};
    assign m_tlast = out_res.done_res;

`ifndef SYNTHESIS
    a_found_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("found without done");

    a_char_done_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && m_tlast |-> m_tuser[1])
        else $error("final name character without found");

    a_chunk_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=>
            (phase_reg == PH_SEARCH) && (tag_reg == '0) && (cnt_reg == '0))
        else $error("state not cleared after chunk end");

    a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg < TAG_W'(TAG_LEN))
        else $error("tag progress out of range");

    a_search_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CAPTURE |-> tag_reg == '0)
        else $error("tag progress kept during capture");
`endif

endmodule

`default_nettype wire
